// ----- hw/rtl/pidf_pkg.sv -----
// ----------------------------------------------------------------------------
// pidf_pkg
// Shared types, register indexes, widths and saturation helper for the
// positional PID with filtered derivative.
// ----------------------------------------------------------------------------
package pidf_pkg;

    // field and datapath widths
    localparam int DATA_W   = 16;               // setpoint, feedback, gains
    localparam int ERR_W    = DATA_W + 1;       // setpoint - feedback
    localparam int DIFF_W   = ERR_W + 1;        // e - prev_error
    localparam int WIDE_W   = 32;               // integral, derivative, drive
    localparam int WGT_W    = 13;               // filter weight
    localparam int MUL_A_W  = DIFF_W;           // narrow multiplier operand
    localparam int MUL_B_W  = WIDE_W;           // wide multiplier operand
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = PROD_W;           // holds the three-term sum
    localparam int FRAC_W   = 12;               // Q.12 fraction bits
    localparam int IDX_W    = 3;

    localparam logic [WGT_W-1:0] Q_ONE = WGT_W'(4096);

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_GAIN_P        = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I        = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D        = 3'd2;
    localparam logic [IDX_W-1:0] REG_DRIVE_UPPER   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DRIVE_LOWER   = 3'd4;
    localparam logic [IDX_W-1:0] REG_FILTER_WEIGHT = 3'd5;

    // reset values
    localparam logic signed [DATA_W-1:0] GAIN_P_RST      = 16'sd205;
    localparam logic signed [DATA_W-1:0] GAIN_I_RST      = 16'sd0;
    localparam logic signed [DATA_W-1:0] GAIN_D_RST      = 16'sd0;
    localparam logic signed [WIDE_W-1:0] DRIVE_UPPER_RST = 32'sd40960;
    localparam logic signed [WIDE_W-1:0] DRIVE_LOWER_RST = -32'sd40960;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,    // wait for a word
        ST_INTEG,   // update integral, multiply error difference by weight
        ST_DFILT,   // multiply filter remainder by previous derivative
        ST_DSUM,    // form derivative, multiply gain_p by error
        ST_PTERM,   // multiply gain_i by integral
        ST_ITERM,   // multiply gain_d by derivative
        ST_DRIVE    // form drive, load output word
    } state_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [WIDE_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7FFF_FFFF);
        lo = -(ACC_W'(32'sh7FFF_FFFF)) - ACC_W'(1);
        if (x > hi)
            return 32'sh7FFF_FFFF;
        else if (x < lo)
            return 32'sh8000_0000;
        else
            return x[WIDE_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/pidf_mul.sv -----
// ----------------------------------------------------------------------------
// pidf_mul
// Shared signed multiplier, 18 by 32 bits, with a registered product.
// ----------------------------------------------------------------------------
module pidf_mul (
    input  logic                                 clk,
    input  logic signed [pidf_pkg::MUL_A_W-1:0]  a,
    input  logic signed [pidf_pkg::MUL_B_W-1:0]  b,
    output logic signed [pidf_pkg::PROD_W-1:0]   prod
);
    import pidf_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ----- hw/rtl/positional_pid_with_derivative_filter.sv -----
// ----------------------------------------------------------------------------
// positional_pid_with_derivative_filter
// Positional PID with conditional anti-windup and a first-order low-pass
// filter on the derivative; five products share one registered multiplier.
// The word runs through INTEG, DFILT, DSUM, PTERM, ITERM and DRIVE in order;
// the five passes through the shared multiplier plus the final sum set the
// pace; s_tready is low while an item runs, so one word is taken at a time.
// Reset (rst_n low, asynchronous): registers take their default values,
// integral, previous error, derivative and drive clear, no result pending.
// ----------------------------------------------------------------------------
module positional_pid_with_derivative_filter (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [pidf_pkg::IDX_W-1:0]       cfg_index,
    input  logic [pidf_pkg::WIDE_W-1:0]      cfg_data,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // [15:0] setpoint, [31:16] feedback
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata    // [31:0] drive
);
    import pidf_pkg::*;

    // configuration
    logic signed [DATA_W-1:0] gain_p_reg;
    logic signed [DATA_W-1:0] gain_i_reg;
    logic signed [DATA_W-1:0] gain_d_reg;
    logic signed [WIDE_W-1:0] drive_upper_reg;
    logic signed [WIDE_W-1:0] drive_lower_reg;
    logic [WGT_W-1:0]         filter_weight_reg;

    // controller state
    state_t                   state_reg;
    state_t                   state_next;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [WIDE_W-1:0] error_sum_reg;
    logic signed [ERR_W-1:0]  prev_error_reg;
    logic signed [WIDE_W-1:0] deriv_reg;
    logic signed [WIDE_W-1:0] prev_drive_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [WIDE_W-1:0]        out_reg;
    logic                     out_valid_reg;

    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] feedback;
    logic                     in_fire;
    logic                     out_fire;
    logic [WGT_W-1:0]         weight;
    logic [WGT_W-1:0]         weight_rem;
    logic signed [DIFF_W-1:0] err_diff;
    logic                     integ_en;
    logic signed [WIDE_W:0]   sum_ext;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   prod_q12;
    logic signed [ACC_W-1:0]   acc_plus_q12;

    assign setpoint = s_tdata[15:0];
    assign feedback = s_tdata[31:16];
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // clamp weight to one and form its remainder
    assign weight     = (filter_weight_reg > Q_ONE) ? Q_ONE : filter_weight_reg;
    assign weight_rem = Q_ONE - weight;
    assign err_diff   = DIFF_W'(err_reg) - DIFF_W'(prev_error_reg);

    // anti-windup gate from previous drive
    always_comb
    begin
        if (prev_drive_reg >= drive_upper_reg)
            integ_en = err_reg[ERR_W-1];
        else if (prev_drive_reg <= drive_lower_reg)
            integ_en = (err_reg != '0) && !err_reg[ERR_W-1];
        else
            integ_en = 1'b1;
    end

    assign sum_ext = (WIDE_W+1)'(error_sum_reg) + (WIDE_W+1)'(err_reg);

    // select multiplier operands per step; hold the derivative product
    // while the final step waits for the result word to drain
    always_comb
    begin
        case (state_reg)
            ST_INTEG:
            begin
                mul_a = err_diff;
                mul_b = MUL_B_W'($signed({1'b0, weight}));
            end
            ST_DFILT:
            begin
                mul_a = MUL_A_W'($signed({1'b0, weight_rem}));
                mul_b = deriv_reg;
            end
            ST_DSUM:
            begin
                mul_a = MUL_A_W'(gain_p_reg);
                mul_b = MUL_B_W'(err_reg);
            end
            ST_PTERM:
            begin
                mul_a = MUL_A_W'(gain_i_reg);
                mul_b = error_sum_reg;
            end
            ST_ITERM, ST_DRIVE:
            begin
                mul_a = MUL_A_W'(gain_d_reg);
                mul_b = deriv_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pidf_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign prod_q12     = prod >>> FRAC_W;
    assign acc_plus_q12 = acc_reg + prod_q12;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_INTEG;
            end
            ST_INTEG: state_next = ST_DFILT;
            ST_DFILT: state_next = ST_DSUM;
            ST_DSUM:  state_next = ST_PTERM;
            ST_PTERM: state_next = ST_ITERM;
            ST_ITERM: state_next = ST_DRIVE;
            ST_DRIVE:
            begin
                if (!out_valid_reg)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg        <= GAIN_P_RST;
            gain_i_reg        <= GAIN_I_RST;
            gain_d_reg        <= GAIN_D_RST;
            drive_upper_reg   <= DRIVE_UPPER_RST;
            drive_lower_reg   <= DRIVE_LOWER_RST;
            filter_weight_reg <= Q_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_P:        gain_p_reg        <= cfg_data[DATA_W-1:0];
                REG_GAIN_I:        gain_i_reg        <= cfg_data[DATA_W-1:0];
                REG_GAIN_D:        gain_d_reg        <= cfg_data[DATA_W-1:0];
                REG_DRIVE_UPPER:   drive_upper_reg   <= cfg_data;
                REG_DRIVE_LOWER:   drive_lower_reg   <= cfg_data;
                REG_FILTER_WEIGHT: filter_weight_reg <= cfg_data[WGT_W-1:0];
                default:           ;
            endcase
        end
    end

    // controller state and sequenced datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
            deriv_reg      <= '0;
            prev_drive_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // drop the result once taken
            if (out_fire)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_INTEG:
                begin
                    if (integ_en)
                        error_sum_reg <= sat32(ACC_W'(sum_ext));
                end
                ST_DSUM:
                    deriv_reg <= sat32(acc_plus_q12);
                ST_DRIVE:
                begin
                    if (!out_valid_reg)
                    begin
                        prev_drive_reg <= sat32(acc_plus_q12);
                        prev_error_reg <= err_reg;
                        out_valid_reg  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    err_reg <= ERR_W'(setpoint) - ERR_W'(feedback);
            end
            ST_DFILT:
                acc_reg <= prod;
            ST_PTERM:
                acc_reg <= prod;
            ST_ITERM:
                acc_reg <= acc_reg + prod;
            ST_DRIVE:
            begin
                if (!out_valid_reg)
                    out_reg <= sat32(acc_plus_q12);
            end
            default: ;
        endcase
    end

endmodule

// ----- hw/rtl/pidf_chk.sv -----
// ----------------------------------------------------------------------------
// pidf_chk
// Port-level checks on the PID block: sequencing of the two streams and
// holding of a stalled result word.
// ----------------------------------------------------------------------------
module pidf_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // busy after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous item still running");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed or dropped");

    // no new result right behind a taken one
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result word repeated or appeared too early");

    // a new result only after the sequencer ran
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready, 1) && !$past(s_tready, 2))
        else $error("result word appeared without a computation");

endmodule

bind positional_pid_with_derivative_filter pidf_chk u_pidf_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- sim/positional_pid_with_derivative_filter_test.sv -----
// ----------------------------------------------------------------------------
// positional_pid_with_derivative_filter_test
// Self-checking bench for the positional PID with filtered derivative. A
// scoreboard predicts every drive word from the setpoint/feedback words the
// block accepts and compares it with the result stream. The run has a short
// directed part, drive soaks into both rails against the integration gate,
// and random register settings with random stalls on both streams.
// ----------------------------------------------------------------------------
package drive_check_pkg;

    import pidf_pkg::*;

    localparam longint DRIVE_MAX = 64'sh7FFF_FFFF;
    localparam longint DRIVE_MIN = -64'sh8000_0000;
    localparam longint UNITY     = 4096;

    class drive_scoreboard;
        // register copies
        longint kp;
        longint ki;
        longint kd;
        longint upper_lim;
        longint lower_lim;
        longint weight;
        // controller state
        longint integ;
        longint last_err;
        longint last_deriv;
        longint last_drive;
        logic [WIDE_W-1:0] drive_q[$];
        int errors;

        function new();
            kp         = longint'(GAIN_P_RST);
            ki         = longint'(GAIN_I_RST);
            kd         = longint'(GAIN_D_RST);
            upper_lim  = longint'(DRIVE_UPPER_RST);
            lower_lim  = longint'(DRIVE_LOWER_RST);
            weight     = UNITY;
            integ      = 0;
            last_err   = 0;
            last_deriv = 0;
            last_drive = 0;
            errors     = 0;
        endfunction

        static function longint clip32(longint x);
            if (x > DRIVE_MAX)
                return DRIVE_MAX;
            if (x < DRIVE_MIN)
                return DRIVE_MIN;
            return x;
        endfunction

        // mirror a register write; unknown indexes fall through
        function void set_reg(logic [IDX_W-1:0] idx, logic [WIDE_W-1:0] value);
            case (idx)
                REG_GAIN_P:        kp        = longint'($signed(value[DATA_W-1:0]));
                REG_GAIN_I:        ki        = longint'($signed(value[DATA_W-1:0]));
                REG_GAIN_D:        kd        = longint'($signed(value[DATA_W-1:0]));
                REG_DRIVE_UPPER:   upper_lim = longint'($signed(value));
                REG_DRIVE_LOWER:   lower_lim = longint'($signed(value));
                REG_FILTER_WEIGHT: weight    = longint'(value[WGT_W-1:0]);
                default: ;
            endcase
        endfunction

        // advance the controller by one sample and queue the drive it yields
        function void note_input(logic signed [DATA_W-1:0] sp, logic signed [DATA_W-1:0] fb);
            longint err;
            longint w;
            longint deriv;
            longint y;
            bit     gate;
            err = longint'(sp) - longint'(fb);
            w   = (weight > UNITY) ? UNITY : weight;
            // anti-windup: the upper test wins when the limits cross
            if (last_drive >= upper_lim)
                gate = (err < 0);
            else if (last_drive <= lower_lim)
                gate = (err > 0);
            else
                gate = 1'b1;
            if (gate)
                integ = clip32(integ + err);
            deriv = clip32((err - last_err) * w + (((UNITY - w) * last_deriv) >>> FRAC_W));
            y = clip32(kp * err + ki * integ + ((kd * deriv) >>> FRAC_W));
            last_err   = err;
            last_deriv = deriv;
            last_drive = y;
            drive_q.push_back(WIDE_W'(y));
        endfunction

        // compare one drive word with the oldest prediction
        function void check_drive(logic [WIDE_W-1:0] got);
            logic [WIDE_W-1:0] want;
            if (drive_q.size() == 0)
            begin
                errors++;
                $display("%0t: drive expected none, got %0d", $time, $signed(got));
            end
            else
            begin
                want = drive_q.pop_front();
                if (want !== got)
                begin
                    errors++;
                    $display("%0t: drive expected %0d, got %0d", $time,
                             $signed(want), $signed(got));
                end
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

endpackage

module positional_pid_with_derivative_filter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pidf_pkg::*;
    import drive_check_pkg::*;

    // indexes the block does not decode
    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 200;
    localparam int CLOSING_ITEMS  = 250;
    localparam int SOAK_ITEMS     = 32;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [WIDE_W-1:0]   cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata   = '0;    // [15:0] setpoint, [31:16] feedback
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [31:0]         m_tdata;           // [31:0] drive

    drive_scoreboard sb;

    // stall odds in percent, per sample on the input side and per cycle on the result side, zero means no idling
    int tx_rate = 0;
    int rx_rate = 0;
    int rx_hold = 0;
    int quiet_cycles = 0;

    logic signed [DATA_W-1:0] prev_sp = '0;
    logic signed [DATA_W-1:0] prev_fb = '0;

    positional_pid_with_derivative_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side: check each accepted word, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_drive(m_tdata);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (rx_rate != 0 && $urandom_range(0, 99) < rx_rate)
            begin
                rx_hold = $urandom_range(1, 15) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // offer one word, hold it until taken, then maybe pause
    task automatic send_sample(input logic signed [DATA_W-1:0] sp,
                               input logic signed [DATA_W-1:0] fb);
        s_tvalid <= 1'b1;
        s_tdata  <= {fb, sp};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(sp, fb);
        prev_sp = sp;
        prev_fb = fb;
        if (tx_rate != 0 && $urandom_range(0, 99) < tx_rate)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // hold off the sender until every drive word is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WIDE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic close_cfg();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_rail();
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return -16'sd1;
        endcase
    endfunction

    // gain in the low half, junk above it
    function automatic logic [WIDE_W-1:0] gain_word();
        logic [DATA_W-1:0] g;
        case ($urandom_range(0, 5))
            0:       g = 16'h8000;
            1:       g = 16'h7FFF;
            2:       g = 16'h0000;
            3:       g = 16'($urandom_range(0, 1024)) - 16'd512;
            default: g = 16'($urandom());
        endcase
        return {16'($urandom()), g};
    endfunction

    function automatic longint limit_value();
        case ($urandom_range(0, 4))
            0:       return DRIVE_MAX;
            1:       return DRIVE_MIN;
            2:       return longint'($signed(32'($urandom())));
            default: return longint'($urandom_range(0, 2000000)) - 1000000;
        endcase
    endfunction

    function automatic logic [WIDE_W-1:0] weight_word();
        logic [WGT_W-1:0] w;
        case ($urandom_range(0, 4))
            0:       w = '0;
            1:       w = Q_ONE;
            2:       w = WGT_W'($urandom_range(4097, 8191));
            default: w = WGT_W'($urandom_range(0, 4096));
        endcase
        return {19'($urandom()), w};
    endfunction

    // new random setting; limits may come out crossed
    task automatic program_random();
        longint a;
        longint b;
        a = limit_value();
        b = limit_value();
        write_reg(REG_GAIN_P, gain_word());
        write_reg(REG_GAIN_I, gain_word());
        write_reg(REG_GAIN_D, gain_word());
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(REG_DRIVE_UPPER, WIDE_W'((a < b) ? a : b));
            write_reg(REG_DRIVE_LOWER, WIDE_W'((a < b) ? b : a));
        end
        else
        begin
            write_reg(REG_DRIVE_UPPER, WIDE_W'((a < b) ? b : a));
            write_reg(REG_DRIVE_LOWER, WIDE_W'((a < b) ? a : b));
        end
        write_reg(REG_FILTER_WEIGHT, weight_word());
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
        close_cfg();
    endtask

    function automatic int pick_rate();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2;
            2:       return 8;
            default: return 25;
        endcase
    endfunction

    task automatic random_sample();
        logic signed [DATA_W-1:0] sp;
        logic signed [DATA_W-1:0] fb;
        logic signed [DATA_W-1:0] base;
        base = 16'($urandom());
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                sp = 16'($urandom());
                fb = 16'($urandom());
            end
            6, 7:
            begin
                // small error around a random operating point
                sp = base + 16'($urandom_range(0, 64)) - 16'sd32;
                fb = base;
            end
            8:
            begin
                sp = pick_rail();
                fb = pick_rail();
            end
            default:
            begin
                // constant error lets the derivative filter decay
                sp = prev_sp;
                fb = prev_fb;
            end
        endcase
        send_sample(sp, fb);
    endtask

    task automatic run_random_phase(input int items, input bit allow_idle);
        int pause_at;
        settle();
        program_random();
        tx_rate  = allow_idle ? pick_rate() : 0;
        rx_rate  = allow_idle ? pick_rate() : 0;
        pause_at = $urandom_range(0, items - 1);
        for (int i = 0; i < items; i++)
        begin
            if (allow_idle && i == pause_at)
                drain();
            random_sample();
        end
    endtask

    // push the drive into one rail and hold it there against the gate
    task automatic soak_drive(input logic signed [DATA_W-1:0] sp,
                              input logic signed [DATA_W-1:0] fb);
        settle();
        write_reg(REG_GAIN_P, '0);
        write_reg(REG_GAIN_I, 32'h0000_1000);
        write_reg(REG_GAIN_D, '0);
        write_reg(REG_DRIVE_UPPER, WIDE_W'(DRIVE_MAX));
        write_reg(REG_DRIVE_LOWER, WIDE_W'(DRIVE_MIN));
        write_reg(REG_FILTER_WEIGHT, WIDE_W'(Q_ONE));
        close_cfg();
        repeat (SOAK_ITEMS) send_sample(sp, fb);
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_rate = 8;
        rx_rate = 8;

        // reset settings, full-scale errors both ways
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);

        // full gains, filter weight above one, writes to undecoded indexes
        settle();
        write_reg(REG_GAIN_P, 32'h0000_7FFF);
        write_reg(REG_GAIN_I, 32'hFFFF_7FFF);
        write_reg(REG_GAIN_D, 32'h0000_8000);
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_DRIVE_UPPER, 32'd40960);
        write_reg(REG_DRIVE_LOWER, -32'sd40960);
        write_reg(REG_FILTER_WEIGHT, 32'd5000);
        write_reg(REG_SPARE_B, 32'h0000_0000);
        close_cfg();
        // saturate the drive high, then low, and check the integration gate
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sd1, 16'sd0);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF);

        // crossed limits, derivative frozen by a zero weight
        settle();
        write_reg(REG_GAIN_I, 32'h0000_8000);
        write_reg(REG_GAIN_D, 32'h0000_7FFF);
        write_reg(REG_DRIVE_UPPER, -32'sd100);
        write_reg(REG_DRIVE_LOWER, 32'sd100);
        write_reg(REG_FILTER_WEIGHT, 32'd0);
        close_cfg();
        send_sample(16'sd100, 16'sd0);
        send_sample(-16'sd100, 16'sd0);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd5, -16'sd5);
        send_sample(-16'sd5, 16'sd5);

        // widest limits, largest weight code, most negative proportional gain
        settle();
        write_reg(REG_GAIN_P, 32'h0000_8000);
        write_reg(REG_DRIVE_UPPER, 32'h7FFF_FFFF);
        write_reg(REG_DRIVE_LOWER, 32'h8000_0000);
        write_reg(REG_FILTER_WEIGHT, 32'h0000_1FFF);
        close_cfg();
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sd0, 16'sd0);

        for (int p = 0; p < RANDOM_PHASES; p++)
            run_random_phase(PHASE_ITEMS, 1'b1);

        // drive saturation at both rails, streams kept busy
        tx_rate = 0;
        rx_rate = 0;
        soak_drive(16'sh7FFF, 16'sh8000);
        soak_drive(16'sh8000, 16'sh7FFF);

        // closing stretch with no idling
        run_random_phase(CLOSING_ITEMS, 1'b0);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/pidf_pkg.sv
hw/rtl/pidf_mul.sv
hw/rtl/positional_pid_with_derivative_filter.sv
hw/rtl/pidf_chk.sv
sim/positional_pid_with_derivative_filter_test.sv
